// ===== sv/fbnn_pkg.sv =====
// Package for the framebuffer nearest-neighbour address generator.
// Holds the raster mode table, shared structs, register indexes and FSM states.
// No dependencies.
package fbnn_pkg;

    // Fixed-point fraction bits of the scaling accumulators.
    localparam int unsigned FracBits = 16;

    // Field widths fixed by the item format.
    localparam int unsigned DimW   = 10;
    localparam int unsigned IdxW   = 20;
    localparam int unsigned AccW   = 27;
    localparam int unsigned StepW  = 26;
    localparam int unsigned CountW = 30;
    localparam int unsigned FsizeW = 19;
    localparam int unsigned OffW   = 9;
    localparam int unsigned ModeW  = 3;

    // Configuration register indexes.
    localparam logic [2:0] RegEnabled = 3'd0;
    localparam logic [2:0] RegMode    = 3'd1;
    localparam logic [2:0] RegPal     = 3'd2;
    localparam logic [2:0] RegWidth   = 3'd3;
    localparam logic [2:0] RegHeight  = 3'd4;

    // Effective modes picked by the PAL flag when the native mode is zero.
    localparam logic [ModeW-1:0] ModeNtsc = 3'd0;
    localparam logic [ModeW-1:0] ModePal  = 3'd2;

    // Raster mode table: width, height and frame size in words.
    localparam logic [DimW-1:0] MODE_W [0:7] = '{
        10'd320, 10'd640, 10'd352, 10'd720, 10'd720, 10'd720, 10'd720, 10'd640
    };
    localparam logic [DimW-1:0] MODE_L [0:7] = '{
        10'd240, 10'd480, 10'd288, 10'd480, 10'd576, 10'd480, 10'd576, 10'd480
    };
    localparam logic [FsizeW-1:0] MODE_SIZE [0:7] = '{
        19'd76800, 19'd307200, 19'd101376, 19'd345600,
        19'd414720, 19'd345600, 19'd414720, 19'd307200
    };

    // Geometry derived from the configuration registers.
    typedef struct packed {
        logic              reject;
        logic              fits;
        logic [DimW-1:0]   w;
        logic [DimW-1:0]   h;
        logic [DimW-1:0]   rw;
        logic [DimW-1:0]   rl;
        logic [FsizeW-1:0] fsize;
        logic [OffW-1:0]   xo;
        logic [OffW-1:0]   yo;
    } fbnn_geom_t;

    // Events raised by a register write.
    typedef struct packed {
        logic wr;
        logic clr_count;
    } fbnn_cfg_evt_t;

    // One classified item in the queue.
    typedef struct packed {
        logic reject;
        logic buf_sel;
    } fbnn_item_t;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [StepW-1:0] dividend;
        logic [DimW-1:0]  divisor;
    } fbnn_div_req_t;

    typedef struct packed {
        logic             done;
        logic [StepW-1:0] quotient;
    } fbnn_div_rsp_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV_COL,
        BK_DIV_ROW,
        BK_MUL,
        BK_SUM
    } fbnn_bk_state_t;

endpackage

// ===== sv/fbnn_cfg.sv =====
// Configuration registers with APB-style access and raster geometry decode.
// Depends on fbnn_pkg.
module fbnn_cfg #(
    parameter int unsigned MAX_CANVAS_DIM = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output fbnn_pkg::fbnn_geom_t   geom,
    output fbnn_pkg::fbnn_cfg_evt_t evt
);
    import fbnn_pkg::*;

    localparam int unsigned DimMax = MAX_CANVAS_DIM - 1;

    logic             enabled_reg, enabled_next;
    logic [ModeW-1:0] mode_reg, mode_next;
    logic             pal_reg, pal_next;
    logic [DimW-1:0]  width_reg, width_next;
    logic [DimW-1:0]  height_reg, height_next;

    logic [2:0]       idx;
    logic             wr;
    logic [DimW-1:0]  val;
    logic [ModeW-1:0] eff_old, eff_new, eff;
    logic [DimW-1:0]  w_sat, h_sat, rw, rl, dx, dy;

    assign idx = paddr[4:2];
    assign wr  = psel && penable && pwrite;
    assign val = pwdata[DimW-1:0];

    // Register write decode.
    always_comb
    begin
        enabled_next = enabled_reg;
        mode_next    = mode_reg;
        pal_next     = pal_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        if (wr)
        begin
            unique case (idx)
                RegEnabled: enabled_next = val[0];
                RegMode:    mode_next    = val[ModeW-1:0];
                RegPal:     pal_next     = val[0];
                RegWidth:   width_next   = val;
                RegHeight:  height_next  = val;
                default:    ;
            endcase
        end
    end

    // Effective raster mode before and after the write.
    assign eff_old = (mode_reg != '0) ? mode_reg : (pal_reg ? ModePal : ModeNtsc);
    assign eff_new = (mode_next != '0) ? mode_next : (pal_next ? ModePal : ModeNtsc);
    assign eff     = eff_old;

    // Write events for the back end.
    always_comb
    begin
        evt.wr        = wr && (idx <= RegHeight);
        evt.clr_count = 1'b0;
        if (wr && idx == RegEnabled && val[0] && !enabled_reg)
        begin
            evt.clr_count = 1'b1;
        end
        if (wr && (idx == RegMode || idx == RegPal) && enabled_reg && eff_new != eff_old)
        begin
            evt.clr_count = 1'b1;
        end
    end

    // Register read mux.
    always_comb
    begin
        unique case (idx)
            RegEnabled: prdata = {31'b0, enabled_reg};
            RegMode:    prdata = {29'b0, mode_reg};
            RegPal:     prdata = {31'b0, pal_reg};
            RegWidth:   prdata = {22'b0, width_reg};
            RegHeight:  prdata = {22'b0, height_reg};
            default:    prdata = '0;
        endcase
    end

    // Canvas saturation and raster geometry.
    assign w_sat = (32'(width_reg) > DimMax) ? DimW'(DimMax) : width_reg;
    assign h_sat = (32'(height_reg) > DimMax) ? DimW'(DimMax) : height_reg;
    assign rw    = MODE_W[eff];
    assign rl    = MODE_L[eff];
    assign dx    = rw - w_sat;
    assign dy    = rl - h_sat;

    always_comb
    begin
        geom.reject = !enabled_reg || (w_sat < 10'd2) || (h_sat < 10'd2);
        geom.fits   = (w_sat <= rw) && (h_sat <= rl);
        geom.w      = w_sat;
        geom.h      = h_sat;
        geom.rw     = rw;
        geom.rl     = rl;
        geom.fsize  = MODE_SIZE[eff];
        geom.xo     = dx[DimW-1:1];
        geom.yo     = dy[DimW-1:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            mode_reg    <= '0;
            pal_reg     <= 1'b0;
            width_reg   <= 10'd320;
            height_reg  <= 10'd240;
        end
        else
        begin
            enabled_reg <= enabled_next;
            mode_reg    <= mode_next;
            pal_reg     <= pal_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
        end
    end

endmodule

// ===== sv/fbnn_front.sv =====
// Front end: accepts items, tags rejected ones, and queues them for the back end.
// Depends on fbnn_pkg.
module fbnn_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 buffer_select,
    input  logic                 reject,
    output logic                 q_valid,
    output fbnn_pkg::fbnn_item_t q_item,
    input  logic                 q_pop
);
    import fbnn_pkg::*;

    localparam int unsigned QDepth = 2;
    localparam int unsigned QAw    = $clog2(QDepth);

    fbnn_item_t         q_mem [QDepth];
    logic [QAw-1:0]     wptr_reg, wptr_next;
    logic [QAw-1:0]     rptr_reg, rptr_next;
    logic [QAw:0]       cnt_reg, cnt_next;
    logic               push;
    logic               pop;

    assign req_ready = (cnt_reg != (QAw+1)'(QDepth));
    assign push      = req_valid && req_ready;
    assign q_valid   = (cnt_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_item    = q_mem[rptr_reg];

    // Queue pointer and fill count update.
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QAw'(QDepth - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QAw'(QDepth - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Queue storage; the item is classified as it is written.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wptr_reg] <= '{reject: reject, buf_sel: buffer_select};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // The fill count never passes the queue depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QAw+1)'(QDepth))
        else $error("queue count above depth");

endmodule

// ===== sv/fbnn_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-frame step sizes.
// Depends on fbnn_pkg.
module fbnn_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fbnn_pkg::fbnn_div_req_t req,
    output fbnn_pkg::fbnn_div_rsp_t rsp
);
    import fbnn_pkg::*;

    localparam int unsigned CntW = $clog2(StepW);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic [DimW-1:0]    rem_reg, rem_next;
    logic [StepW-1:0]   quo_reg, quo_next;
    logic [DimW-1:0]    dvs_reg, dvs_next;
    logic [DimW:0]      shifted;
    logic [DimW+1:0]    diff;
    logic               ge;

    // One trial subtraction per cycle.
    assign shifted = {rem_reg, quo_reg[StepW-1]};
    assign diff    = {1'b0, shifted} - {2'b0, dvs_reg};
    assign ge      = !diff[DimW+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DimW-1:0] : shifted[DimW-1:0];
            quo_next = {quo_reg[StepW-2:0], ge};
            if (cnt_reg == CntW'(StepW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // A result only follows a division in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a division");

endmodule

// ===== sv/fbnn_back.sv =====
// Back end: frame state, step divisions, address arithmetic and the result register.
// Depends on fbnn_pkg and drives fbnn_div through a request struct.
module fbnn_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fbnn_pkg::fbnn_geom_t    geom,
    input  fbnn_pkg::fbnn_cfg_evt_t evt,
    input  logic                    q_valid,
    input  fbnn_pkg::fbnn_item_t    q_item,
    output logic                    q_pop,
    output fbnn_pkg::fbnn_div_req_t div_req,
    input  fbnn_pkg::fbnn_div_rsp_t div_rsp,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic                    status,
    output logic [19:0]             source_index,
    output logic [19:0]             dest_index,
    output logic                    frame_last,
    output logic [31:0]             control_word
);
    import fbnn_pkg::*;

    fbnn_bk_state_t     state_reg, state_next;

    logic               in_frame_reg, in_frame_next;
    logic               latched_reg, latched_next;
    logic [DimW-1:0]    col_reg, col_next;
    logic [DimW-1:0]    row_reg, row_next;
    logic [AccW-1:0]    col_acc_reg, col_acc_next;
    logic [AccW-1:0]    row_acc_reg, row_acc_next;
    logic [StepW-1:0]   col_step_reg, col_step_next;
    logic [StepW-1:0]   row_step_reg, row_step_next;
    logic [CountW-1:0]  fc_reg, fc_next;

    logic [2*DimW:0]    prod_a_reg, prod_a_next;
    logic [2*DimW:0]    prod_b_reg, prod_b_next;
    logic [DimW:0]      add_a_reg, add_a_next;
    logic [DimW:0]      add_b_reg, add_b_next;

    logic               out_valid_reg, out_valid_next;
    logic               status_reg, status_next;
    logic [IdxW-1:0]    src_reg, src_next;
    logic [IdxW-1:0]    dst_reg, dst_next;
    logic               last_reg, last_next;
    logic [31:0]        ctrl_reg, ctrl_next;

    logic               out_free;
    logic [DimW:0]      col_inc;
    logic [DimW:0]      mul_a_l, mul_b_l;
    logic [FsizeW-1:0]  base;
    logic               is_last;
    logic [CountW-1:0]  fc_inc;

    assign out_free = !out_valid_reg || rsp_ready;
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign base     = latched_reg ? geom.fsize : '0;
    assign fc_inc   = fc_reg + 1'b1;
    assign is_last  = geom.fits ?
        (col_reg == geom.w - 1'b1) && (row_reg == geom.h - 1'b1) :
        (col_reg == geom.rw - 1'b1) && (row_reg == geom.rl - 1'b1);

    // Multiplier operands: centered walk or scaled walk.
    assign mul_a_l = geom.fits ? {1'b0, row_reg} : row_acc_reg[AccW-1:FracBits];
    assign mul_b_l = geom.fits ? {1'b0, row_reg} + {2'b0, geom.yo} : {1'b0, row_reg};

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && !q_item.reject)
                begin
                    state_next = (!in_frame_reg && !geom.fits) ? BK_DIV_COL : BK_MUL;
                end
            end
            BK_DIV_COL:
            begin
                if (div_rsp.done)
                begin
                    state_next = BK_DIV_ROW;
                end
            end
            BK_DIV_ROW:
            begin
                if (div_rsp.done)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_SUM;
            end
            BK_SUM:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        q_pop          = 1'b0;
        div_req        = '{start: 1'b0, dividend: {geom.w, 16'b0}, divisor: geom.rw};
        in_frame_next  = in_frame_reg;
        latched_next   = latched_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        col_acc_next   = col_acc_reg;
        row_acc_next   = row_acc_reg;
        col_step_next  = col_step_reg;
        row_step_next  = row_step_reg;
        fc_next        = fc_reg;
        prod_a_next    = prod_a_reg;
        prod_b_next    = prod_b_reg;
        add_a_next     = add_a_reg;
        add_b_next     = add_b_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        status_next    = status_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        last_next      = last_reg;
        ctrl_next      = ctrl_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && q_item.reject)
                begin
                    // A rejected item closes any open frame.
                    if (out_free)
                    begin
                        q_pop          = 1'b1;
                        in_frame_next  = 1'b0;
                        out_valid_next = 1'b1;
                        status_next    = 1'b1;
                        src_next       = '0;
                        dst_next       = '0;
                        last_next      = 1'b0;
                        ctrl_next      = '0;
                    end
                end
                else if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (!in_frame_reg)
                    begin
                        // First item of a frame.
                        latched_next = q_item.buf_sel;
                        col_next     = '0;
                        row_next     = '0;
                        if (geom.fits)
                        begin
                            in_frame_next = 1'b1;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                        end
                    end
                end
            end
            BK_DIV_COL:
            begin
                if (div_rsp.done)
                begin
                    col_step_next = div_rsp.quotient;
                    col_acc_next  = {2'b0, div_rsp.quotient[StepW-1:1]};
                    div_req       = '{start: 1'b1, dividend: {geom.h, 16'b0},
                                      divisor: geom.rl};
                end
            end
            BK_DIV_ROW:
            begin
                if (div_rsp.done)
                begin
                    row_step_next = div_rsp.quotient;
                    row_acc_next  = {2'b0, div_rsp.quotient[StepW-1:1]};
                    in_frame_next = 1'b1;
                end
            end
            BK_MUL:
            begin
                prod_a_next = {10'b0, mul_a_l} * {11'b0, geom.w};
                prod_b_next = {10'b0, mul_b_l} * {11'b0, geom.rw};
                add_a_next  = geom.fits ? {1'b0, col_reg} : col_acc_reg[AccW-1:FracBits];
                add_b_next  = geom.fits ? {1'b0, col_reg} + {2'b0, geom.xo}
                                        : {1'b0, col_reg};
            end
            BK_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = 1'b0;
                    src_next       = IdxW'(prod_a_reg + {10'b0, add_a_reg});
                    dst_next       = IdxW'({3'b0, base} + {1'b0, prod_b_reg}
                                           + {11'b0, add_b_reg});
                    last_next      = is_last;
                    ctrl_next      = '0;
                    if (is_last)
                    begin
                        fc_next       = fc_inc;
                        ctrl_next     = {fc_inc, 1'b0, latched_reg};
                        in_frame_next = 1'b0;
                    end
                    // Advance the raster position.
                    if (geom.fits)
                    begin
                        if (col_inc >= {1'b0, geom.w})
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_inc[DimW-1:0];
                        end
                    end
                    else
                    begin
                        col_acc_next = col_acc_reg + {1'b0, col_step_reg};
                        if (col_inc >= {1'b0, geom.rw})
                        begin
                            col_next     = '0;
                            col_acc_next = {2'b0, col_step_reg[StepW-1:1]};
                            row_next     = row_reg + 1'b1;
                            row_acc_next = row_acc_reg + {1'b0, row_step_reg};
                        end
                        else
                        begin
                            col_next = col_inc[DimW-1:0];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Register writes abandon the frame and may restart the count.
        if (evt.wr)
        begin
            in_frame_next = 1'b0;
        end
        if (evt.clr_count)
        begin
            fc_next = '0;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = status_reg;
    assign source_index = src_reg;
    assign dest_index   = dst_reg;
    assign frame_last   = last_reg;
    assign control_word = ctrl_reg;

    // Payload registers.
    always_ff @(posedge clk)
    begin
        latched_reg  <= latched_next;
        col_acc_reg  <= col_acc_next;
        row_acc_reg  <= row_acc_next;
        col_step_reg <= col_step_next;
        row_step_reg <= row_step_next;
        prod_a_reg   <= prod_a_next;
        prod_b_reg   <= prod_b_next;
        add_a_reg    <= add_a_next;
        add_b_reg    <= add_b_next;
        status_reg   <= status_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        last_reg     <= last_next;
        ctrl_reg     <= ctrl_next;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            in_frame_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_frame_reg  <= in_frame_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            fc_reg        <= fc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Address arithmetic only runs inside an open frame.
    a_mul_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_MUL |-> in_frame_reg)
        else $error("address arithmetic outside a frame");

    // A frame never ends on a rejected item.
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> !status_reg)
        else $error("frame end on a rejected item");

    // Rejected items carry zero addresses and no control word.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg |-> src_reg == '0 && dst_reg == '0 && ctrl_reg == '0)
        else $error("rejected item with nonzero payload");

endmodule

// ===== sv/framebuffer_center_or_nn_scale_addr_top.sv =====
// Top level of the framebuffer centering / nearest-neighbour address generator.
// Depends on fbnn_pkg, fbnn_cfg, fbnn_front, fbnn_div and fbnn_back.
//
//  Port group     Kind          Payload
//  req_*          valid/ready   buffer_select
//  rsp_*          valid/ready   status, source_index, dest_index, frame_last,
//                               control_word
//  p*             APB-style     enabled, native_mode, pal_menu, canvas_width,
//                               canvas_height at byte addresses 0, 4, 8, 12, 16
//
//  A transfer inside an open frame passes through the back-end sequencer
//  states for pop, multiply and sum; a rejected item is popped in idle.
//  The first item of a scaled frame adds two divisions, column step then
//  row step, on the shared restoring divider, each giving 26 quotient bits;
//  a centered frame needs no division.
//  Reset is asynchronous and active low; there is no clearing pass.
//  A two-entry queue lets the input side run ahead of the back end, and a
//  result register holds a finished item while the next one is worked on.
module framebuffer_center_or_nn_scale_addr_top #(
    parameter int unsigned MAX_CANVAS_DIM = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        buffer_select,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic        status,
    output logic [19:0] source_index,
    output logic [19:0] dest_index,
    output logic        frame_last,
    output logic [31:0] control_word
);
    import fbnn_pkg::*;

    fbnn_geom_t    geom;
    fbnn_cfg_evt_t evt;
    fbnn_item_t    q_item;
    fbnn_div_req_t div_req;
    fbnn_div_rsp_t div_rsp;
    logic          q_valid;
    logic          q_pop;

    assign pready = 1'b1;

    // Register file and geometry.
    fbnn_cfg #(
        .MAX_CANVAS_DIM(MAX_CANVAS_DIM)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .geom    (geom),
        .evt     (evt)
    );

    // Item intake and queue.
    fbnn_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .buffer_select (buffer_select),
        .reject        (geom.reject),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // Shared step divider.
    fbnn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Frame walker and result register.
    fbnn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom),
        .evt          (evt),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .source_index (source_index),
        .dest_index   (dest_index),
        .frame_last   (frame_last),
        .control_word (control_word)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for framebuffer_center_or_nn_scale_addr_top.
// Drives items and APB register writes, predicts every transfer in-line and
// compares each result field by field. Depends on fbnn_pkg and the top level.
`timescale 1ns / 100ps

module tb;
    import fbnn_pkg::*;

    localparam int unsigned MAX_CANVAS_DIM = 1024;
    localparam int unsigned CYCLE_LIMIT    = 2000000;
    localparam int unsigned RANDOM_ITEMS   = 320;

    // One transfer as seen on the result channel.
    typedef struct {
        logic        status;
        logic [19:0] source_index;
        logic [19:0] dest_index;
        logic        frame_last;
        logic [31:0] control_word;
    } xfer_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid     = 1'b0;
    logic        req_ready;
    logic        buffer_select = 1'b0;
    logic        rsp_valid;
    logic        rsp_ready     = 1'b0;
    logic        status;
    logic [19:0] source_index;
    logic [19:0] dest_index;
    logic        frame_last;
    logic [31:0] control_word;

    // Expected transfers, oldest first.
    xfer_t       pending_xfers[$];
    int unsigned failures    = 0;
    int unsigned cycle_count = 0;
    bit          idle_on     = 1'b1;
    int unsigned stall_left  = 0;

    // Shadow of the configuration registers.
    logic        cfg_enabled;
    logic [2:0]  cfg_mode;
    logic        cfg_pal;
    logic [9:0]  cfg_w;
    logic [9:0]  cfg_h;

    // Shadow of the frame walker.
    logic [29:0] frame_cnt;
    logic        in_frame;
    logic        latched_buf;
    logic [9:0]  col_cnt;
    logic [9:0]  row_cnt;
    logic [26:0] col_acc;
    logic [26:0] row_acc;
    logic [25:0] col_step;
    logic [25:0] row_step;

    framebuffer_center_or_nn_scale_addr_top #(
        .MAX_CANVAS_DIM(MAX_CANVAS_DIM)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .buffer_select(buffer_select),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .source_index (source_index),
        .dest_index   (dest_index),
        .frame_last   (frame_last),
        .control_word (control_word)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Run-time guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** framebuffer_center_or_nn_scale_addr_top: FAILED **");
            $finish;
        end
    end

    // Raster geometry of each mode.
    function automatic void raster_dims(input logic [2:0] m,
                                        output int unsigned rw, output int unsigned rl);
        case (m)
            3'd0:    begin rw = 320; rl = 240; end
            3'd1:    begin rw = 640; rl = 480; end
            3'd2:    begin rw = 352; rl = 288; end
            3'd3:    begin rw = 720; rl = 480; end
            3'd4:    begin rw = 720; rl = 576; end
            3'd5:    begin rw = 720; rl = 480; end
            3'd6:    begin rw = 720; rl = 576; end
            default: begin rw = 640; rl = 480; end
        endcase
    endfunction

    function automatic logic [2:0] raster_mode();
        if (cfg_mode != 3'd0)
            return cfg_mode;
        return cfg_pal ? ModePal : ModeNtsc;
    endfunction

    function automatic int unsigned clamp_dim(input logic [9:0] v);
        return (v > MAX_CANVAS_DIM - 1) ? MAX_CANVAS_DIM - 1 : int'(v);
    endfunction

    // Number of items in one whole frame under the current settings, 0 if rejected.
    function automatic int unsigned frame_items();
        int unsigned w, h, rw, rl;
        w = clamp_dim(cfg_w);
        h = clamp_dim(cfg_h);
        raster_dims(raster_mode(), rw, rl);
        if (!cfg_enabled || w < 2 || h < 2)
            return 0;
        if (w <= rw && h <= rl)
            return w * h;
        return rw * rl;
    endfunction

    // Register write side effects on the shadow state.
    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [2:0] old_mode;
        logic [9:0] v;
        old_mode = raster_mode();
        v        = value[9:0];
        in_frame = 1'b0;
        case (idx)
            RegEnabled:
            begin
                if (v[0] && !cfg_enabled)
                    frame_cnt = '0;
                cfg_enabled = v[0];
            end
            RegMode:   cfg_mode = v[2:0];
            RegPal:    cfg_pal  = v[0];
            RegWidth:  cfg_w    = v;
            RegHeight: cfg_h    = v;
            default:   ;
        endcase
        if ((idx == RegMode || idx == RegPal) && cfg_enabled && raster_mode() != old_mode)
            frame_cnt = '0;
    endfunction

    // Address of one pixel transfer; advances the shadow frame walker.
    function automatic xfer_t predict_xfer(input logic bsel);
        int unsigned w, h, rw, rl, base, xo, yo, src, dst;
        bit          fits, last;
        xfer_t       r;
        w = clamp_dim(cfg_w);
        h = clamp_dim(cfg_h);
        raster_dims(raster_mode(), rw, rl);
        r.status       = 1'b0;
        r.source_index = '0;
        r.dest_index   = '0;
        r.frame_last   = 1'b0;
        r.control_word = '0;

        if (!cfg_enabled || w < 2 || h < 2)
        begin
            r.status = 1'b1;
            in_frame = 1'b0;
            return r;
        end

        fits = (w <= rw) && (h <= rl);

        // First step of a frame latches the buffer and sets up the steps.
        if (!in_frame)
        begin
            latched_buf = bsel;
            in_frame    = 1'b1;
            col_cnt     = '0;
            row_cnt     = '0;
            col_step    = 26'((w << FracBits) / rw);
            row_step    = 26'((h << FracBits) / rl);
            col_acc     = 27'(col_step >> 1);
            row_acc     = 27'(row_step >> 1);
        end

        base = latched_buf * rw * rl;

        if (fits)
        begin
            xo   = (rw - w) / 2;
            yo   = (rl - h) / 2;
            src  = row_cnt * w + col_cnt;
            dst  = base + (row_cnt + yo) * rw + xo + col_cnt;
            last = (col_cnt == w - 1) && (row_cnt == h - 1);
            col_cnt = col_cnt + 10'd1;
            if (col_cnt >= w)
            begin
                col_cnt = '0;
                row_cnt = row_cnt + 10'd1;
            end
        end
        else
        begin
            src  = (row_acc >> FracBits) * w + (col_acc >> FracBits);
            dst  = base + row_cnt * rw + col_cnt;
            last = (col_cnt == rw - 1) && (row_cnt == rl - 1);
            col_cnt = col_cnt + 10'd1;
            col_acc = col_acc + 27'(col_step);
            if (col_cnt >= rw)
            begin
                col_cnt = '0;
                col_acc = 27'(col_step >> 1);
                row_cnt = row_cnt + 10'd1;
                row_acc = row_acc + 27'(row_step);
            end
        end

        r.source_index = src[19:0];
        r.dest_index   = dst[19:0];
        if (last)
        begin
            frame_cnt      = frame_cnt + 30'd1;
            r.frame_last   = 1'b1;
            r.control_word = {frame_cnt, 1'b0, latched_buf};
            in_frame       = 1'b0;
        end
        return r;
    endfunction

    // Result side: random stall bursts while idling is on, else always ready.
    always @(negedge clk)
    begin
        if (!idle_on)
            rsp_ready <= 1'b1;
        else if (stall_left != 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end
        else
            rsp_ready <= 1'b1;
    end

    // Compare each accepted result with the oldest expected transfer.
    always @(posedge clk)
    begin
        xfer_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_xfers.size() == 0)
            begin
                $error("unexpected result item: status %0d source_index %0d",
                       status, source_index);
                failures = failures + 1;
            end
            else
            begin
                want = pending_xfers.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    failures = failures + 1;
                end
                if (source_index !== want.source_index)
                begin
                    $error("source_index: expected %0d, actual %0d",
                           want.source_index, source_index);
                    failures = failures + 1;
                end
                if (dest_index !== want.dest_index)
                begin
                    $error("dest_index: expected %0d, actual %0d",
                           want.dest_index, dest_index);
                    failures = failures + 1;
                end
                if (frame_last !== want.frame_last)
                begin
                    $error("frame_last: expected %0d, actual %0d",
                           want.frame_last, frame_last);
                    failures = failures + 1;
                end
                if (control_word !== want.control_word)
                begin
                    $error("control_word: expected 0x%08h, actual 0x%08h",
                           want.control_word, control_word);
                    failures = failures + 1;
                end
            end
        end
    end

    // Sends one item; starts and returns at a falling edge.
    task automatic send_item(input logic bsel);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid     <= 1'b1;
        buffer_select <= bsel;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_xfers.push_back(predict_xfer(bsel));
        @(negedge clk);
    endtask

    // Sends n items with random buffer selects.
    task automatic send_random(input int unsigned n);
        repeat (n) send_item(1'(
            $urandom_range(0, 1)));
    endtask

    // Waits until every expected result is in, then lets the back end settle.
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_xfers.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle. Bits above the field may carry junk.
    // The item channel is emptied first so that no item is in flight.
    task automatic write_reg(input logic [2:0] idx, input logic [9:0] value);
        logic [31:0] word;
        drain();
        word = $urandom();
        if ($urandom_range(0, 1) == 0)
            word = '0;
        word[9:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_reg(idx, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(input logic [2:0] m, input logic pal,
                                input logic [9:0] w, input logic [9:0] h);
        write_reg(RegMode, {7'd0, m});
        write_reg(RegPal, {9'd0, pal});
        write_reg(RegWidth, w);
        write_reg(RegHeight, h);
    endtask

    // Out of reset the output is inactive, so every item is rejected.
    task automatic test_disabled_rejects();
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b1);
        drain();
    endtask

    // Canvases narrower or shorter than two pixels are rejected.
    task automatic test_tiny_canvas_rejects();
        write_reg(RegEnabled, 10'd1);
        write_reg(RegWidth, 10'd1);
        send_item(1'b1);
        write_reg(RegWidth, 10'd0);
        send_item(1'b0);
        write_reg(RegWidth, 10'd2);
        write_reg(RegHeight, 10'd1);
        send_item(1'b1);
        write_reg(RegHeight, 10'd0);
        send_item(1'b0);
        drain();
    endtask

    // Centered frames: smallest canvas in both buffers, and an exact fit.
    task automatic test_centered_frames();
        set_geometry(3'd0, 1'b0, 10'd2, 10'd2);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b1);
        send_item(1'b0);
        drain();
        set_geometry(3'd4, 1'b0, 10'd720, 10'd576);
        send_item(1'b1);
        send_item(1'b1);
        drain();
    endtask

    // Scaled frames: largest canvas, and one column past the PAL raster.
    task automatic test_scaled_extremes();
        set_geometry(3'd1, 1'b0, 10'd1023, 10'd1023);
        send_item(1'b1);
        send_item(1'b0);
        drain();
        set_geometry(3'd0, 1'b1, 10'd353, 10'd2);
        send_item(1'b0);
        send_item(1'b1);
        drain();
    endtask

    // Frame count clears on enable rising and on a raster mode change;
    // any write abandons a frame in progress.
    task automatic test_count_clears();
        set_geometry(3'd0, 1'b0, 10'd2, 10'd2);
        send_random(4);
        send_random(2);
        drain();
        write_reg(RegPal, 10'd1);
        send_random(4);
        drain();
        write_reg(RegEnabled, 10'd0);
        write_reg(RegEnabled, 10'd1);
        write_reg(RegMode, 10'd2);
        send_random(4);
        drain();
    endtask

    // Scaled walk across more than one raster line.
    task automatic test_scaled_rows();
        set_geometry(3'd0, 1'b0, 10'd400, 10'd10);
        send_random(330);
        drain();
    endtask

    function automatic logic [9:0] random_dim(input int unsigned small_max);
        case ($urandom_range(0, 9))
            0:       return 10'($urandom_range(0, 1));
            1:       return 10'($urandom_range(321, 1023));
            2:       return 10'd1023;
            default: return 10'($urandom_range(2, small_max));
        endcase
    endfunction

    // Random settings, each followed by a run of items that may end mid-frame.
    task automatic test_random_phases();
        int unsigned sent, n, fsize, rw, rl, w, h;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) != 0)
                write_reg(RegEnabled, 10'($urandom_range(0, 9) != 0));
            if ($urandom_range(0, 3) != 0)
                write_reg(RegMode, 10'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) != 0)
                write_reg(RegPal, 10'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) != 0)
                write_reg(RegWidth, random_dim(8));
            if ($urandom_range(0, 3) != 0)
                write_reg(RegHeight, random_dim(6));

            fsize = frame_items();
            w = clamp_dim(cfg_w);
            h = clamp_dim(cfg_h);
            raster_dims(raster_mode(), rw, rl);
            if (fsize == 0)
                n = $urandom_range(1, 6);
            else if (w > rw || h > rl)
                n = $urandom_range(5, 40);
            else
            begin
                n = fsize * $urandom_range(1, 3) + $urandom_range(0, 3);
                if (n > 80)
                    n = $urandom_range(20, 80);
            end
            send_random(n);
            sent = sent + n;
            drain();
        end
    endtask

    // Items back to back with no idling: a scaled run, then whole centered frames.
    task automatic test_full_rate();
        idle_on = 1'b0;
        write_reg(RegEnabled, 10'd1);
        set_geometry(3'd0, 1'b0, 10'd2, 10'd241);
        send_random(40);
        drain();
        write_reg(RegWidth, 10'd3);
        write_reg(RegHeight, 10'd2);
        send_random(2 * frame_items());
        drain();
    endtask

    initial
    begin
        cfg_enabled = 1'b0;
        cfg_mode    = '0;
        cfg_pal     = 1'b0;
        cfg_w       = 10'd320;
        cfg_h       = 10'd240;
        frame_cnt   = '0;
        in_frame    = 1'b0;
        latched_buf = 1'b0;
        col_cnt     = '0;
        row_cnt     = '0;
        col_acc     = '0;
        row_acc     = '0;
        col_step    = '0;
        row_step    = '0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_disabled_rejects();
        test_tiny_canvas_rejects();
        test_centered_frames();
        test_scaled_extremes();
        test_count_clears();
        test_scaled_rows();
        test_random_phases();
        test_full_rate();

        if (failures == 0)
            $display("** framebuffer_center_or_nn_scale_addr_top: PASSED **");
        else
            $display("** framebuffer_center_or_nn_scale_addr_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fbnn_pkg.sv
sv/fbnn_cfg.sv
sv/fbnn_front.sv
sv/fbnn_div.sv
sv/fbnn_back.sv
sv/framebuffer_center_or_nn_scale_addr_top.sv
verif/tb.sv
